@@ rtl/transposition_table_engine_defines.svh @@
// assertion macros used by the transposition table engine rtl
`ifndef TRANSPOSITION_TABLE_ENGINE_DEFINES_SVH
`define TRANSPOSITION_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tte_pkg.sv @@
// shared types, constants and the replacement helper function of the transposition table engine
`default_nettype none
package tte_pkg;
	localparam int TABLE_SIZE   = 1024;
	localparam int ADDR_W       = $clog2(TABLE_SIZE);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int KEY_W        = 64;
	localparam int PLY_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int DEPTH_W      = 8;
	localparam int TYPE_W       = 2;
	localparam int LIMIT_W      = 11;
	localparam int AGE_W        = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 1'b1;

	// request kinds
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// bound types
	localparam logic [TYPE_W-1:0] TY_EXACT  = 2'd0;
	localparam logic [TYPE_W-1:0] TY_QEXACT = 2'd1;

	typedef enum logic [2:0] {
		ST_MISS   = 3'd0,
		ST_HIT    = 3'd1,
		ST_STORED = 3'd2,
		ST_REJECT = 3'd3,
		ST_DROP   = 3'd4
	} status_t;

	// classified request word travelling from front to engine
	typedef struct packed {
		logic                    kind;
		logic [KEY_W-1:0]        key;
		logic [PLY_BITS-1:0]     ply;
		logic [TYPE_W-1:0]       etype;
		logic [DEPTH_W-1:0]      depth;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [ADDR_W-1:0]       home;
		logic                    key_zero;
	} item_t;

	// stored entry beside the key
	typedef struct packed {
		logic [TYPE_W-1:0]       etype;
		logic [DEPTH_W-1:0]      depth;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [PLY_BITS-1:0]     last;
	} entry_t;

	// same-key replacement policy: bound type priority, then depth
	function automatic logic may_replace(input logic [TYPE_W-1:0] old_ty,
		input logic [DEPTH_W-1:0] old_dp, input logic [TYPE_W-1:0] ty,
		input logic [DEPTH_W-1:0] dp);
		logic r;
		if (old_ty == TY_EXACT && ty != TY_EXACT)
			r = 1'b0;
		else if (old_ty == TY_QEXACT && ty != TY_QEXACT && ty != TY_EXACT)
			r = 1'b0;
		else if (old_ty != TY_EXACT && ty == TY_EXACT)
			r = 1'b1;
		else if (old_ty != TY_QEXACT && ty == TY_QEXACT)
			r = 1'b1;
		else
			r = (dp >= old_dp);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/tte_if.sv @@
// channel interfaces of the transposition table engine
`default_nettype none
interface tte_req_if import tte_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [KEY_W-1:0]        key;
	logic [PLY_BITS-1:0]     ply;
	logic [TYPE_W-1:0]       entry_type;
	logic [DEPTH_W-1:0]      entry_depth;
	logic [PAYLOAD_BITS-1:0] entry_payload;
	modport source (output valid, kind, key, ply, entry_type, entry_depth, entry_payload,
		input ready);
	modport sink (input valid, kind, key, ply, entry_type, entry_depth, entry_payload,
		output ready);
endinterface

interface tte_rsp_if import tte_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              status;
	logic [TYPE_W-1:0]       out_type;
	logic [DEPTH_W-1:0]      out_depth;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [ADDR_W-1:0]       slot_index;
	logic [CNT_W-1:0]        occupied_count;
	modport source (output valid, status, out_type, out_depth, out_payload, slot_index,
		occupied_count, input ready);
	modport sink (input valid, status, out_type, out_depth, out_payload, slot_index,
		occupied_count, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/tte_front.sv @@
// front stage: takes request words and classifies them (home slot, zero key)
`default_nettype none
module tte_front import tte_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	tte_req_if.sink     req,
	output logic        push_valid,
	output item_t       push_item,
	input  wire         push_ready
);
	logic  v_s1;
	item_t item_s1;
	item_t cls;

	// classification of the incoming word
	always_comb begin
		cls.kind     = req.kind;
		cls.key      = req.key;
		cls.ply      = req.ply;
		cls.etype    = req.entry_type;
		cls.depth    = req.entry_depth;
		cls.payload  = req.entry_payload;
		cls.home     = req.key[ADDR_W-1:0];
		cls.key_zero = (req.key == '0);
	end

	assign req.ready  = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= cls;
		end
	end
endmodule
`default_nettype wire

@@ rtl/tte_queue.sv @@
// two-word queue between front and engine
`default_nettype none
module tte_queue import tte_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push_valid,
	input  item_t  push_item,
	output logic   push_ready,
	output logic   pop_valid,
	output item_t  pop_item,
	input  wire    pop
);
	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_item   = buf_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

@@ rtl/tte_engine.sv @@
// back end: slot memories, probing sequencer, clearing sweeps and result register
`default_nettype none
`include "transposition_table_engine_defines.svh"
module tte_engine import tte_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	input  wire [LIMIT_W-1:0]  load_limit,
	input  wire [AGE_W-1:0]    age_limit,
	tte_rsp_if.source          rsp
);
	typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_WIPE, S_PREP, S_RD, S_CHK} state_t;

	state_t               state_q;
	item_t                cur_q;
	logic [ADDR_W-1:0]    s_q;
	logic [ADDR_W-1:0]    n_q;
	logic [CNT_W-1:0]     count_q;
	logic                 pend_q;
	logic [PLY_BITS-1:0]  cply_q;
	logic                 ov_q;
	status_t              st_q;
	entry_t               oent_q;
	logic [ADDR_W-1:0]    oslot_q;

	logic [KEY_W-1:0]     key_mem [TABLE_SIZE];
	entry_t               ent_mem [TABLE_SIZE];
	logic [KEY_W-1:0]     key_rd_q;
	entry_t               ent_rd_q;

	logic                 kwe;
	logic [KEY_W-1:0]     kwd;
	logic                 ewe;
	entry_t               ewd;
	logic                 k_empty;
	logic                 k_same;
	logic                 aged;
	logic [PLY_BITS-1:0]  ply_diff;
	logic                 last_probe;
	logic                 done;
	logic                 do_write;
	logic                 do_touch;
	status_t              chk_st;
	logic [ADDR_W-1:0]    chk_slot;
	logic [CNT_W-1:0]     count_nx;
	logic                 sched;
	logic                 out_free;

	assign out_free = !ov_q || rsp.ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free;
	assign sched    = (count_q >= load_limit) && !pend_q;

	// probe evaluation on the slot just read
	always_comb begin
		k_empty    = (key_rd_q == '0);
		k_same     = (key_rd_q == cur_q.key);
		ply_diff   = cur_q.ply - ent_rd_q.last;
		aged       = (ply_diff >= age_limit);
		last_probe = (n_q == {ADDR_W{1'b1}});
		done       = 1'b1;
		do_write   = 1'b0;
		do_touch   = 1'b0;
		chk_st     = ST_MISS;
		chk_slot   = s_q;
		if (cur_q.kind == KIND_GET) begin
			if (k_same && !k_empty) begin
				do_touch = 1'b1;
				chk_st   = ST_HIT;
			end else if (k_empty) begin
				chk_st = ST_MISS;
			end else if (last_probe) begin
				chk_st   = ST_MISS;
				chk_slot = cur_q.home;
			end else begin
				done = 1'b0;
			end
		end else if (pend_q) begin
			do_write = !k_empty;
			chk_st   = k_empty ? ST_DROP : ST_STORED;
		end else if (k_empty || k_same) begin
			do_write = k_empty || may_replace(ent_rd_q.etype, ent_rd_q.depth,
				cur_q.etype, cur_q.depth);
			chk_st   = do_write ? ST_STORED : ST_REJECT;
		end else if (aged) begin
			do_write = 1'b1;
			chk_st   = ST_STORED;
		end else if (last_probe) begin
			chk_st   = ST_REJECT;
			chk_slot = cur_q.home;
		end else begin
			done = 1'b0;
		end
		count_nx = count_q;
		if (do_write && k_empty && count_q < CNT_W'(TABLE_SIZE)) begin
			count_nx = count_q + 1'b1;
		end
	end

	// memory write selection
	always_comb begin
		kwe = 1'b0;
		kwd = '0;
		ewe = 1'b0;
		ewd = '{etype: cur_q.etype, depth: cur_q.depth, payload: cur_q.payload,
			last: cur_q.ply};
		case (state_q)
			S_SWEEP, S_WIPE: begin
				kwe = 1'b1;
			end
			S_CHK: begin
				if (do_write) begin
					kwe = 1'b1;
					kwd = cur_q.key;
					ewe = 1'b1;
				end else if (do_touch) begin
					ewe       = 1'b1;
					ewd       = ent_rd_q;
					ewd.last  = cur_q.ply;
				end
			end
			default: begin
			end
		endcase
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (kwe) key_mem[s_q] <= kwd;
		if (ewe) ent_mem[s_q] <= ewd;
		key_rd_q <= key_mem[s_q];
		ent_rd_q <= ent_mem[s_q];
	end

	// sequencer, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			s_q     <= '0;
			n_q     <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			cply_q  <= '0;
			ov_q    <= 1'b0;
			st_q    <= ST_MISS;
			oent_q  <= '0;
			oslot_q <= '0;
			cur_q   <= '0;
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			case (state_q)
				S_SWEEP: begin
					s_q <= s_q + 1'b1;
					if (s_q == {ADDR_W{1'b1}}) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) begin
						cur_q <= q_item;
						n_q   <= '0;
						if (q_item.kind == KIND_GET) begin
							s_q     <= q_item.home;
							state_q <= S_RD;
						end else if (pend_q && q_item.ply != cply_q) begin
							s_q     <= '0;
							state_q <= S_WIPE;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_WIPE: begin
					s_q <= s_q + 1'b1;
					if (s_q == {ADDR_W{1'b1}}) begin
						count_q <= '0;
						pend_q  <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (sched) begin
						pend_q <= 1'b1;
						cply_q <= cur_q.ply;
					end
					if (cur_q.key_zero) begin
						ov_q    <= 1'b1;
						st_q    <= ST_REJECT;
						oent_q  <= '0;
						oslot_q <= cur_q.home;
						state_q <= S_IDLE;
					end else begin
						s_q     <= cur_q.home;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (done) begin
						count_q <= count_nx;
						ov_q    <= 1'b1;
						st_q    <= chk_st;
						oent_q  <= (chk_st == ST_HIT) ? ent_rd_q : '0;
						oslot_q <= chk_slot;
						state_q <= S_IDLE;
					end else begin
						s_q     <= s_q + 1'b1;
						n_q     <= n_q + 1'b1;
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = ov_q;
	assign rsp.status         = st_q;
	assign rsp.out_type       = oent_q.etype;
	assign rsp.out_depth      = oent_q.depth;
	assign rsp.out_payload    = oent_q.payload;
	assign rsp.slot_index     = oslot_q;
	assign rsp.occupied_count = count_q;

	// checks on count, wipe and lookup behaviour
	`TTE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_SIZE),
		"occupied count above table size")
	`TTE_ASSERT_NXT(a_wipe_zero, clk, arst_n,
		state_q == S_WIPE && s_q == {ADDR_W{1'b1}}, count_q == '0 && !pend_q,
		"wipe did not reset count")
	`TTE_ASSERT_NXT(a_get_count, clk, arst_n,
		state_q == S_CHK && cur_q.kind == KIND_GET, $stable(count_q),
		"lookup changed occupied count")
endmodule
`default_nettype wire

@@ rtl/transposition_table_engine.sv @@
// Transposition table engine: hash table of search results with linear probing.
// Channels: req (request word: kind, key, ply, entry fields), rsp (one result word
// per request, in request order) and cfg (register writes: index 0 load_limit,
// index 1 age_limit). All are valid/ready; a word moves when both are high.
// Configuration must be written only while no request is in flight; the block
// does not enforce this. cfg.ready is always high.
// Path: the front stage register, the two-word queue, then the engine, which pops
// a new request only from idle: a lookup reads and compares each probed slot in
// turn, a store first passes a prep state. Each probe is one read of the
// single-port key and entry memories followed by a compare. A store that triggers
// a scheduled clear first runs a wipe over all 1024 slots. After reset a clearing
// pass over all 1024 slots empties the key memory; requests queue up in the front
// meanwhile. If rsp is stalled, the finished result holds in the output register,
// the front and queue take up to three more requests, and then req.ready falls.
`default_nettype none
module transposition_table_engine import tte_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	tte_req_if.sink   req,
	tte_rsp_if.source rsp,
	tte_cfg_if.sink   cfg
);
	logic [LIMIT_W-1:0] load_limit_q;
	logic [AGE_W-1:0]   age_limit_q;
	logic               f_valid;
	item_t              f_item;
	logic               f_ready;
	logic               q_valid;
	item_t              q_item;
	logic               q_pop;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LIMIT_W'(716);
			age_limit_q  <= AGE_W'(8);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOAD_LIMIT: load_limit_q <= cfg.data[LIMIT_W-1:0];
				CFG_AGE_LIMIT:  age_limit_q  <= cfg.data[AGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready)
	);

	tte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	tte_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.load_limit (load_limit_q),
		.age_limit  (age_limit_q),
		.rsp        (rsp)
	);
endmodule
`default_nettype wire

@@ dv/transposition_table_engine_tb.sv @@
// self-checking testbench of the transposition table engine with a behavioural mirror
`timescale 1ns / 1ps
`default_nettype none
module transposition_table_engine_tb;
	import tte_pkg::*;

	typedef struct {
		status_t                 status;
		logic [TYPE_W-1:0]       etype;
		logic [DEPTH_W-1:0]      depth;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [ADDR_W-1:0]       slot;
		logic [CNT_W-1:0]        count;
	} outcome_t;

	logic clk;
	logic arst_n;

	tte_req_if req ();
	tte_rsp_if rsp ();
	tte_cfg_if cfg ();

	transposition_table_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// mirror of the table and its control state
	logic [KEY_W-1:0]    mirror_key [TABLE_SIZE];
	entry_t              mirror_ent [TABLE_SIZE];
	logic [CNT_W-1:0]    mirror_count;
	logic                mirror_pending;
	logic [PLY_BITS-1:0] mirror_clear_ply;
	logic [LIMIT_W-1:0]  load_lim;
	logic [AGE_W-1:0]    age_lim;

	outcome_t awaited_results[$];
	int       fail_count;
	int       send_idle_pct;
	int       recv_stall_pct;
	logic [PLY_BITS-1:0] cur_ply;
	logic [KEY_W-1:0]    key_pool [48];

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("Regression FAIL");
		$finish;
	end

	// fill a slot, counting only newly occupied ones
	function automatic void store_entry(int s, logic [KEY_W-1:0] key, logic [TYPE_W-1:0] ty,
		logic [DEPTH_W-1:0] dp, logic [PAYLOAD_BITS-1:0] pay, logic [PLY_BITS-1:0] ply);
		if (mirror_key[s] == '0 && mirror_count < TABLE_SIZE)
			mirror_count++;
		mirror_ent[s] = '{etype: ty, depth: dp, payload: pay, last: ply};
		mirror_key[s] = key;
	endfunction

	// same key: bound type priority first, then depth
	function automatic logic replace_ok(int s, logic [TYPE_W-1:0] ty, logic [DEPTH_W-1:0] dp);
		logic [TYPE_W-1:0] old;
		old = mirror_ent[s].etype;
		if (old == TY_EXACT && ty != TY_EXACT)
			return 1'b0;
		if (old == TY_QEXACT && ty != TY_QEXACT && ty != TY_EXACT)
			return 1'b0;
		if (old != TY_EXACT && ty == TY_EXACT)
			return 1'b1;
		if (old != TY_QEXACT && ty == TY_QEXACT)
			return 1'b1;
		return dp >= mirror_ent[s].depth;
	endfunction

	// expected outcome of one request, updating the mirror
	function automatic outcome_t predict_probe(logic kind, logic [KEY_W-1:0] key,
		logic [PLY_BITS-1:0] ply, logic [TYPE_W-1:0] ty, logic [DEPTH_W-1:0] dp,
		logic [PAYLOAD_BITS-1:0] pay);
		outcome_t o;
		int home;
		int s;
		bit found;
		bit aged;
		logic [PLY_BITS-1:0] gap;
		o.status = ST_MISS;
		o.etype = '0;
		o.depth = '0;
		o.payload = '0;
		home = int'(key[ADDR_W-1:0]);
		s = home;
		found = 0;
		aged = 0;
		if (kind == KIND_GET) begin
			for (int n = 0; n < TABLE_SIZE && !found; n++) begin
				if (mirror_key[s] == '0 || mirror_key[s] == key)
					found = 1;
				else
					s = (s + 1) % TABLE_SIZE;
			end
			if (!found)
				s = home;
			if (found && mirror_key[s] != '0) begin
				mirror_ent[s].last = ply;
				o.status = ST_HIT;
				o.etype = mirror_ent[s].etype;
				o.depth = mirror_ent[s].depth;
				o.payload = mirror_ent[s].payload;
			end
		end else begin
			// scheduled clear fires on a ply change
			if (mirror_pending && ply != mirror_clear_ply) begin
				foreach (mirror_key[i])
					mirror_key[i] = '0;
				mirror_count = '0;
				mirror_pending = 1'b0;
			end
			if (mirror_count >= load_lim && !mirror_pending) begin
				mirror_pending = 1'b1;
				mirror_clear_ply = ply;
			end
			if (key == '0) begin
				o.status = ST_REJECT;
			end else if (mirror_pending) begin
				if (mirror_key[s] != '0) begin
					store_entry(s, key, ty, dp, pay, ply);
					o.status = ST_STORED;
				end else begin
					o.status = ST_DROP;
				end
			end else begin
				for (int n = 0; n < TABLE_SIZE && !found; n++) begin
					gap = ply - mirror_ent[s].last;
					if (mirror_key[s] == '0 || mirror_key[s] == key) begin
						found = 1;
					end else if (gap >= age_lim) begin
						found = 1;
						aged = 1;
					end else begin
						s = (s + 1) % TABLE_SIZE;
					end
				end
				if (!found) begin
					s = home;
					o.status = ST_REJECT;
				end else if (mirror_key[s] == '0 || aged || replace_ok(s, ty, dp)) begin
					store_entry(s, key, ty, dp, pay, ply);
					o.status = ST_STORED;
				end else begin
					o.status = ST_REJECT;
				end
			end
		end
		o.slot = s[ADDR_W-1:0];
		o.count = mirror_count;
		return o;
	endfunction

	// send one request word and predict its result on acceptance
	task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [PLY_BITS-1:0] ply,
		logic [TYPE_W-1:0] ty, logic [DEPTH_W-1:0] dp, logic [PAYLOAD_BITS-1:0] pay);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.kind = kind;
		req.key = key;
		req.ply = ply;
		req.entry_type = ty;
		req.entry_depth = dp;
		req.entry_payload = pay;
		do
			@(posedge clk);
		while (!req.ready);
		awaited_results.push_back(predict_probe(kind, key, ply, ty, dp, pay));
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain_results();
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		drain_results();
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		do
			@(posedge clk);
		while (!cfg.ready);
		if (idx == CFG_LOAD_LIMIT)
			load_lim = value[LIMIT_W-1:0];
		else
			age_lim = value[AGE_W-1:0];
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result word status %0d slot %0d", $time,
					rsp.status, rsp.slot_index);
				fail_count++;
			end else begin
				e = awaited_results.pop_front();
				if (rsp.status !== e.status || rsp.out_type !== e.etype ||
					rsp.out_depth !== e.depth || rsp.out_payload !== e.payload ||
					rsp.slot_index !== e.slot || rsp.occupied_count !== e.count) begin
					$display("%0t: expected st %0d ty %0d dp %0d pay %h slot %0d cnt %0d",
						$time, e.status, e.etype, e.depth, e.payload, e.slot, e.count);
					$display("%0t: actual   st %0d ty %0d dp %0d pay %h slot %0d cnt %0d",
						$time, rsp.status, rsp.out_type, rsp.out_depth, rsp.out_payload,
						rsp.slot_index, rsp.occupied_count);
					fail_count++;
				end
			end
		end
	end

	// hits, misses, key zero, type priority, collisions, ageing, ply wrap
	task automatic test_basic_cases();
		logic [KEY_W-1:0] k;
		k = 64'h1234_5678_9abc_d005;
		send_request(KIND_GET, k, 16'd10, 2'd0, 8'd0, 32'd0);
		send_request(KIND_PUT, 64'd0, 16'd10, 2'd0, 8'd9, 32'h1);
		send_request(KIND_GET, 64'd0, 16'd10, 2'd0, 8'd0, 32'd0);
		send_request(KIND_PUT, k, 16'd10, 2'd2, 8'd5, 32'hffff_ffff);
		send_request(KIND_PUT, k, 16'd10, 2'd3, 8'd4, 32'h2);
		send_request(KIND_PUT, k, 16'd10, 2'd1, 8'd0, 32'h3);
		send_request(KIND_PUT, k, 16'd10, 2'd2, 8'd255, 32'h4);
		send_request(KIND_PUT, k, 16'd10, 2'd0, 8'd0, 32'h5);
		send_request(KIND_PUT, k, 16'd10, 2'd1, 8'd255, 32'h6);
		send_request(KIND_PUT, k, 16'd10, 2'd0, 8'd255, 32'h7);
		send_request(KIND_PUT, k, 16'd10, 2'd0, 8'd3, 32'h8);
		send_request(KIND_GET, k, 16'd11, 2'd0, 8'd0, 32'd0);
		// colliding key lands in the next slot; later the home slot's entry ages out
		send_request(KIND_PUT, 64'hffff_ffff_ffff_fc05, 16'd11, 2'd3, 8'd1, 32'h0);
		send_request(KIND_GET, 64'hffff_ffff_ffff_fc05, 16'd12, 2'd0, 8'd0, 32'd0);
		send_request(KIND_GET, 64'hffff_ffff_ffff_f805, 16'd12, 2'd0, 8'd0, 32'd0);
		send_request(KIND_PUT, 64'hffff_ffff_ffff_ffff, 16'd65535, 2'd1, 8'd2, 32'h9);
		send_request(KIND_PUT, 64'h8000_0000_0000_0005, 16'd2, 2'd2, 8'd7, 32'ha);
		send_request(KIND_GET, k, 16'd2, 2'd0, 8'd0, 32'd0);
		send_request(KIND_GET, 64'h8000_0000_0000_0005, 16'd3, 2'd0, 8'd0, 32'd0);
	endtask

	// fill a long run of slots, probe across it, then schedule and run a clear
	task automatic test_long_chain();
		write_register(CFG_LOAD_LIMIT, 16'd2047);
		write_register(CFG_AGE_LIMIT, 16'd65535);
		for (int i = 0; i < 300; i++)
			send_request(KIND_PUT, 64'(i) + 64'(TABLE_SIZE) * 64'd7, 16'd100,
				2'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
		send_request(KIND_GET, 64'd5 + 64'(TABLE_SIZE) * 64'd9, 16'd100, 2'd0, 8'd0, 32'd0);
		send_request(KIND_PUT, 64'd5 + 64'(TABLE_SIZE) * 64'd9, 16'd100, 2'd0, 8'd1, 32'h1);
		write_register(CFG_LOAD_LIMIT, 16'd4);
		send_request(KIND_PUT, 64'd6 + 64'(TABLE_SIZE) * 64'd9, 16'd100, 2'd0, 8'd1, 32'h2);
		send_request(KIND_PUT, 64'd7 + 64'(TABLE_SIZE) * 64'd9, 16'd101, 2'd1, 8'd1, 32'h3);
		send_request(KIND_GET, 64'd6 + 64'(TABLE_SIZE) * 64'd9, 16'd101, 2'd0, 8'd0, 32'd0);
	endtask

	// random mix over a small clustered key pool
	task automatic test_random_traffic(int count, int lim, int age);
		logic [KEY_W-1:0] k;
		logic [DEPTH_W-1:0] dp;
		write_register(CFG_LOAD_LIMIT, 16'(lim));
		write_register(CFG_AGE_LIMIT, 16'(age));
		repeat (count) begin
			case ($urandom_range(19))
				0: k = 64'd0;
				1: k = {$urandom, $urandom};
				default: k = key_pool[$urandom_range(47)];
			endcase
			if ($urandom_range(9) == 0)
				cur_ply = cur_ply + 16'd1;
			else if ($urandom_range(49) == 0)
				cur_ply = 16'($urandom);
			case ($urandom_range(9))
				0: dp = 8'd0;
				1: dp = 8'd255;
				default: dp = 8'($urandom);
			endcase
			send_request(1'($urandom_range(1)), k, cur_ply, 2'($urandom_range(3)), dp,
				$urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_GET;
		req.key = '0;
		req.ply = '0;
		req.entry_type = '0;
		req.entry_depth = '0;
		req.entry_payload = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_LOAD_LIMIT;
		cfg.data = '0;
		rsp.ready = 1'b0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_ply = 16'hfff0;
		foreach (mirror_key[i]) begin
			mirror_key[i] = '0;
			mirror_ent[i] = '0;
		end
		mirror_count = '0;
		mirror_pending = 1'b0;
		mirror_clear_ply = '0;
		load_lim = 11'd716;
		age_lim = 16'd8;
		// clustered homes force long probe chains
		foreach (key_pool[i])
			key_pool[i] = {$urandom, 16'($urandom_range(65535)), 6'($urandom),
				10'($urandom_range(15))};
		key_pool[47] = 64'h0000_0000_0000_03ff;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_basic_cases();
		test_long_chain();
		test_random_traffic(90, 24, 8);
		send_idle_pct = 86;
		test_random_traffic(80, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		test_random_traffic(80, 40, 65535);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		test_random_traffic(80, 12, 3);

		drain_results();
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
